>>> hdl/salsa_pkg.sv
// Shared types and constants for the Salsa20 stream cipher block.
// Used by salsa_ctrl, salsa_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package salsa_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned BLK_W  = 26;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_KEY0  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_KEY1  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_KEY2  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_KEY3  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_NONCE = 3'd4;
  localparam logic [IDX_W-1:0] CFG_MODE  = 3'd5;

  // "expand 32-byte k" / "expand 16-byte k"
  localparam logic [31:0] SIG0       = 32'h6170_7865;
  localparam logic [31:0] SIG1_LONG  = 32'h3320_646e;
  localparam logic [31:0] SIG2_LONG  = 32'h7962_2d32;
  localparam logic [31:0] SIG1_SHORT = 32'h3120_646e;
  localparam logic [31:0] SIG2_SHORT = 32'h7962_2d36;
  localparam logic [31:0] SIG3       = 32'h6b20_6574;

  // Quarter-round word indexes: [0 column/1 row round][lane][a,b,c,d]
  localparam logic [3:0] QIDX [2][4][4] = '{
    '{ '{4'd0,  4'd4,  4'd8,  4'd12},
       '{4'd5,  4'd9,  4'd13, 4'd1},
       '{4'd10, 4'd14, 4'd2,  4'd6},
       '{4'd15, 4'd3,  4'd7,  4'd11} },
    '{ '{4'd0,  4'd1,  4'd2,  4'd3},
       '{4'd5,  4'd6,  4'd7,  4'd4},
       '{4'd10, 4'd11, 4'd8,  4'd9},
       '{4'd15, 4'd12, 4'd13, 4'd14} }
  };

  // Rotate amount of each quarter-round step
  localparam logic [4:0] ROT [4] = '{5'd7, 5'd9, 5'd13, 5'd18};

  typedef struct packed {
    logic       capture;   // latch the accepted request
    logic       hit_out;   // emit the accepted request from the cached block
    logic       load;      // load the working state from the input words
    logic       round;     // apply one quarter-round step on all four lanes
    logic [1:0] step;
    logic       row;       // 0: column round, 1: row round
    logic       finish;    // add the input words back, mark block cached
    logic       miss_out;  // emit the latched request from the new block
  } salsa_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } salsa_status_t;

  function automatic logic [31:0] rotl32(logic [31:0] v, logic [4:0] s);
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

>>> hdl/salsa_ctrl.sv
// Sequencer for the Salsa20 block: accepts requests, runs the round schedule
// on a cache miss and issues commands to salsa_datapath. Uses salsa_pkg.
`timescale 1ns / 1ps

module salsa_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  salsa_pkg::salsa_status_t status,
  output salsa_pkg::salsa_cmd_t    cmd
);

  localparam int unsigned DR_W = $clog2(DOUBLE_ROUNDS + 1);
  localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [1:0]      step;
  logic            row;
  logic [DR_W-1:0] dround;
  logic            last_step;

  assign last_step = (step == 2'd3) && row && (dround == DR_LAST);

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.step     = step;
    cmd.row      = row;
    case (state)
      ST_IDLE: begin
        s_tready = status.out_free;
        if (s_tvalid && status.out_free) begin
          cmd.capture = 1'b1;
          if (status.hit) begin
            cmd.hit_out = 1'b1;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (last_step) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.finish = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.miss_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= '0;
      row    <= 1'b0;
      dround <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        step   <= '0;
        row    <= 1'b0;
        dround <= '0;
      end else if (cmd.round) begin
        // advance step, then half round, then double round
        step <= step + 2'd1;
        if (step == 2'd3) begin
          row <= ~row;
          if (row) begin
            dround <= dround + DR_W'(1);
          end
        end
      end
    end
  end

  a_final_to_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINAL |=> state == ST_EMIT)
    else $error("finish not followed by emit");

  a_load_starts_round: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.round && step == 2'd0 && !row && dround == '0)
    else $error("round schedule did not restart after load");

  a_one_output: assert property (@(posedge clk) disable iff (rst)
    !(cmd.hit_out && cmd.miss_out))
    else $error("two output writes in one cycle");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE && status.out_free)
    else $error("ready outside idle");

endmodule

>>> hdl/salsa_datapath.sv
// Datapath for the Salsa20 block: configuration registers, working state that
// doubles as the cached keystream block, quarter-round lanes and output register.
// Uses salsa_pkg; driven by salsa_ctrl.
`timescale 1ns / 1ps

module salsa_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [salsa_pkg::IDX_W-1:0]          cfg_index,
  input  logic [salsa_pkg::KEY_W-1:0]          cfg_data,
  input  logic [salsa_pkg::DATA_W+salsa_pkg::POS_W-1:0] s_tdata,
  input  logic                                 s_tlast,
  output logic [salsa_pkg::DATA_W-1:0]         m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic                                 m_tlast,
  input  salsa_pkg::salsa_cmd_t                cmd,
  output salsa_pkg::salsa_status_t             status
);

  logic [salsa_pkg::KEY_W-1:0] key0, key1, key2, key3, nonce;
  logic                        long_mode;

  logic [31:0]                 w [16];
  logic [31:0]                 w_next [16];
  logic [31:0]                 init_w [16];
  logic [salsa_pkg::KEY_W-1:0] hi0, hi1;

  logic                        block_valid;
  logic [salsa_pkg::BLK_W-1:0] cached_blk;

  logic [salsa_pkg::DATA_W-1:0] item_data;
  logic [salsa_pkg::POS_W-1:0]  item_pos;
  logic                         item_last;

  logic [salsa_pkg::DATA_W-1:0] s_data;
  logic [salsa_pkg::POS_W-1:0]  s_pos;
  logic [5:0]                   rd_off;
  logic [31:0]                  rd_word;
  logic [7:0]                   ks_byte;

  assign s_data = s_tdata[salsa_pkg::DATA_W-1:0];
  assign s_pos  = s_tdata[salsa_pkg::DATA_W+salsa_pkg::POS_W-1:salsa_pkg::DATA_W];

  // Configuration; any listed write drops the cached block
  always_ff @(posedge clk) begin
    if (rst) begin
      key0      <= '0;
      key1      <= '0;
      key2      <= '0;
      key3      <= '0;
      nonce     <= '0;
      long_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        salsa_pkg::CFG_KEY0:  key0      <= cfg_data;
        salsa_pkg::CFG_KEY1:  key1      <= cfg_data;
        salsa_pkg::CFG_KEY2:  key2      <= cfg_data;
        salsa_pkg::CFG_KEY3:  key3      <= cfg_data;
        salsa_pkg::CFG_NONCE: nonce     <= cfg_data;
        salsa_pkg::CFG_MODE:  long_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    hi0        = long_mode ? key2 : key0;
    hi1        = long_mode ? key3 : key1;
    init_w[0]  = salsa_pkg::SIG0;
    init_w[1]  = key0[31:0];
    init_w[2]  = key0[63:32];
    init_w[3]  = key1[31:0];
    init_w[4]  = key1[63:32];
    init_w[5]  = long_mode ? salsa_pkg::SIG1_LONG : salsa_pkg::SIG1_SHORT;
    init_w[6]  = nonce[31:0];
    init_w[7]  = nonce[63:32];
    init_w[8]  = {6'd0, item_pos[31:6]};
    init_w[9]  = 32'd0;
    init_w[10] = long_mode ? salsa_pkg::SIG2_LONG : salsa_pkg::SIG2_SHORT;
    init_w[11] = hi0[31:0];
    init_w[12] = hi0[63:32];
    init_w[13] = hi1[31:0];
    init_w[14] = hi1[63:32];
    init_w[15] = salsa_pkg::SIG3;
  end

  // One quarter-round step on four independent lanes: q[s+1] ^= rotl(q[s] + q[s-1])
  always_comb begin : round_step
    logic [1:0] p_src;
    logic [1:0] p_dst;
    logic [1:0] p_prv;
    logic [3:0] ia, ib, ic;
    w_next = w;
    p_src  = cmd.step;
    p_dst  = cmd.step + 2'd1;
    p_prv  = cmd.step + 2'd3;
    for (int l = 0; l < 4; l++) begin
      ia = salsa_pkg::QIDX[cmd.row][l][p_src];
      ib = salsa_pkg::QIDX[cmd.row][l][p_dst];
      ic = salsa_pkg::QIDX[cmd.row][l][p_prv];
      w_next[ib] = w[ib] ^ salsa_pkg::rotl32(w[ia] + w[ic], salsa_pkg::ROT[p_src]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w <= init_w;
    end else if (cmd.round) begin
      w <= w_next;
    end else if (cmd.finish) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= w[i] + init_w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_valid <= 1'b0;
      cached_blk  <= '0;
    end else if (cfg_we && cfg_index <= salsa_pkg::CFG_MODE) begin
      block_valid <= 1'b0;
    end else if (cmd.finish) begin
      block_valid <= 1'b1;
      cached_blk  <= item_pos[31:6];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_data <= s_data;
      item_pos  <= s_pos;
      item_last <= s_tlast;
    end
  end

  // Keystream byte: new request on a hit, latched request after a rebuild
  assign rd_off  = cmd.miss_out ? item_pos[5:0] : s_pos[5:0];
  assign rd_word = w[rd_off[5:2]];
  assign ks_byte = rd_word[{rd_off[1:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.hit_out || cmd.miss_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_out) begin
      m_tdata <= s_data ^ ks_byte;
      m_tlast <= s_tlast;
    end else if (cmd.miss_out) begin
      m_tdata <= item_data ^ ks_byte;
      m_tlast <= item_last;
    end
  end

  assign status.hit      = block_valid && (cached_blk == s_pos[31:6]);
  assign status.out_free = !m_tvalid || m_tready;

  a_finish_caches: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && !cfg_we |=> block_valid)
    else $error("block not cached after rebuild");

  a_hit_needs_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.hit_out |-> block_valid)
    else $error("hit served without a cached block");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while waiting");

endmodule

>>> hdl/salsa20_stream_cipher_top.sv
// Salsa20/20 stream cipher, one byte per request, with a one-block keystream cache.
// Hit (same 64-byte block as cached): result registered on accept, 1 byte/cycle while
// the output is free. Miss: latch, load, rounds on the four-lane quarter-round unit at one
// quarter-round step per cycle, add-back, emit; one request in flight during a rebuild.
// Reset (rst, synchronous): no block cached, key and nonce zero, 256-bit key mode.
`timescale 1ns / 1ps

module salsa20_stream_cipher_top #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] data_in, [39:8] byte_position
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] data_out
  output logic        m_tlast,   // end_of_message_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  salsa_pkg::salsa_cmd_t    cmd;
  salsa_pkg::salsa_status_t status;

  salsa_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  salsa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> dv/salsa20_stream_cipher_top_tb.sv
// Self-checking testbench for salsa20_stream_cipher_top: byte stream in, XORed bytes out.
// Predicts the Salsa20/20 keystream in a scoreboard class; depends on salsa_pkg and the top level.
`timescale 1ns / 1ps

module salsa20_stream_cipher_top_tb;

  localparam int unsigned DOUBLE_ROUNDS   = 10;
  localparam int unsigned ITEMS_PER_PHASE = 232;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned SETTLE_CYCLES   = 100;

  // Indexes past the register list; writes there must change nothing
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef enum {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_result_t;

  class keystream_checker;
    logic [63:0]  key [4];
    logic [63:0]  nonce;
    logic         long_key;
    logic [31:0]  ks_words [16];
    logic [31:0]  mix_state [16];
    logic [31:0]  cached_blk;
    bit           cache_ok;
    byte_result_t expected_bytes [$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  rebuilds;

    function new();
      foreach (key[i]) key[i] = '0;
      nonce    = '0;
      long_key = 1'b1;
      cached_blk = '0;
      cache_ok = 0;
      errors   = 0;
      checked  = 0;
      rebuilds = 0;
    endfunction

    function logic [31:0] rotate_left(logic [31:0] v, int unsigned s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void mix(int a, int b, int c, int d);
      mix_state[b] ^= rotate_left(mix_state[a] + mix_state[d], 7);
      mix_state[c] ^= rotate_left(mix_state[b] + mix_state[a], 9);
      mix_state[d] ^= rotate_left(mix_state[c] + mix_state[b], 13);
      mix_state[a] ^= rotate_left(mix_state[d] + mix_state[c], 18);
    endfunction

    function void build_keystream(logic [31:0] blk);
      logic [31:0] init [16];
      logic [63:0] hi0;
      logic [63:0] hi1;
      hi0 = long_key ? key[2] : key[0];
      hi1 = long_key ? key[3] : key[1];
      init[0]  = salsa_pkg::SIG0;
      init[1]  = key[0][31:0];
      init[2]  = key[0][63:32];
      init[3]  = key[1][31:0];
      init[4]  = key[1][63:32];
      init[5]  = long_key ? salsa_pkg::SIG1_LONG : salsa_pkg::SIG1_SHORT;
      init[6]  = nonce[31:0];
      init[7]  = nonce[63:32];
      init[8]  = blk;
      init[9]  = '0;
      init[10] = long_key ? salsa_pkg::SIG2_LONG : salsa_pkg::SIG2_SHORT;
      init[11] = hi0[31:0];
      init[12] = hi0[63:32];
      init[13] = hi1[31:0];
      init[14] = hi1[63:32];
      init[15] = salsa_pkg::SIG3;
      foreach (init[i]) mix_state[i] = init[i];
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
        mix(0, 4, 8, 12);
        mix(5, 9, 13, 1);
        mix(10, 14, 2, 6);
        mix(15, 3, 7, 11);
        mix(0, 1, 2, 3);
        mix(5, 6, 7, 4);
        mix(10, 11, 8, 9);
        mix(15, 12, 13, 14);
      end
      foreach (ks_words[i]) ks_words[i] = mix_state[i] + init[i];
      cached_blk = blk;
      cache_ok   = 1;
      rebuilds++;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        salsa_pkg::CFG_KEY0:  key[0]   = val;
        salsa_pkg::CFG_KEY1:  key[1]   = val;
        salsa_pkg::CFG_KEY2:  key[2]   = val;
        salsa_pkg::CFG_KEY3:  key[3]   = val;
        salsa_pkg::CFG_NONCE: nonce    = val;
        salsa_pkg::CFG_MODE:  long_key = val[0];
        default:              return;
      endcase
      cache_ok = 0;
    endfunction

    function void note_request(logic [7:0] d, logic [31:0] p, logic e);
      logic [31:0]  word;
      byte_result_t res;
      if (!cache_ok || cached_blk != {6'd0, p[31:6]})
        build_keystream({6'd0, p[31:6]});
      word = ks_words[p[5:2]] >> (8 * p[1:0]);
      res.data = d ^ word[7:0];
      res.last = e;
      expected_bytes.push_back(res);
    endfunction

    function void check_result(logic [7:0] d, logic l);
      byte_result_t exp_res;
      if (expected_bytes.size() == 0) begin
        $display("%0t ERROR unexpected result: expected none, got data %02h last %0b",
                 $time, d, l);
        errors++;
        return;
      end
      exp_res = expected_bytes.pop_front();
      checked++;
      if (d !== exp_res.data) begin
        $display("%0t ERROR data_out: expected %02h, got %02h", $time, exp_res.data, d);
        errors++;
      end
      if (l !== exp_res.last) begin
        $display("%0t ERROR end_of_message_out: expected %0b, got %0b",
                 $time, exp_res.last, l);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [7:0] data_in, [39:8] byte_position
  logic        s_tlast = 1'b0; // end_of_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] data_out
  logic        m_tlast;        // end_of_message_out
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  keystream_checker sb = new();
  flow_mode_t  flow = FLOW_FREE;
  bit          src_steady = 0;
  int unsigned sink_burst = 0;
  int unsigned cfg_writes = 0;

  salsa20_stream_cipher_top #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit src_idles();
    case (flow)
      FLOW_SRC_GAPS: return $urandom_range(99) < 85;
      FLOW_BOTH:     return $urandom_range(99) < 38;
      default:       return 0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (flow)
      FLOW_SINK_STALLS: return $urandom_range(99) < 85;
      FLOW_BOTH:        return $urandom_range(99) < 38;
      default:          return 0;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Result side: check what was taken at this edge, then pick next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tlast);
    if (sink_burst != 0) begin
      sink_burst <= sink_burst - 1;
      m_tready   <= 1'b1;
    end else begin
      if ($urandom_range(199) == 0)
        sink_burst <= 40;
      m_tready <= !sink_stalls();
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic [31:0] p, input logic e);
    while (!src_steady && src_idles()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p, d};
    s_tlast  <= e;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(d, p, e);
  endtask

  // Drop valid and hold until every predicted byte has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Watchdog: count cycles in which no handshake or write happens
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t timeout: %0d bytes still outstanding", $time, sb.pending());
    $display("salsa20_stream_cipher_top_tb: errors");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [31:0] start;
    bit          paused;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset config (zero key, long key mode), block edges, extremes
    src_steady = 1;
    push_byte(8'h00, 32'h0000_0000, 1'b0);
    push_byte(8'hFF, 32'h0000_0001, 1'b0);
    push_byte(8'hA5, 32'h0000_003F, 1'b1);
    push_byte(8'h5A, 32'h0000_0040, 1'b0);
    push_byte(8'h3C, 32'h0000_0000, 1'b0);
    push_byte(8'hFF, 32'hFFFF_FFFF, 1'b1);
    push_byte(8'h81, 32'hFFFF_FFC0, 1'b0);
    push_byte(8'h01, 32'h8000_0000, 1'b1);

    // Short key with noise above bit 0 of the mode value, all-ones key and nonce
    wait_for_results();
    write_cfg(salsa_pkg::CFG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    write_cfg(salsa_pkg::CFG_KEY0, '1);
    write_cfg(salsa_pkg::CFG_KEY1, '1);
    write_cfg(salsa_pkg::CFG_KEY2, '1);
    write_cfg(salsa_pkg::CFG_KEY3, '1);
    write_cfg(salsa_pkg::CFG_NONCE, '1);
    push_byte(8'h00, 32'h0000_0000, 1'b0);
    push_byte(8'hFF, 32'h0000_0005, 1'b1);
    push_byte(8'h77, 32'h0000_FA11, 1'b0);
    push_byte(8'hC3, 32'hFFFF_FFFF, 1'b1);

    // Writes past the register list leave everything as is
    wait_for_results();
    write_cfg(CFG_SPARE_LO, rand64());
    write_cfg(CFG_SPARE_HI, '1);
    push_byte(8'h12, 32'h0000_0001, 1'b0);
    push_byte(8'hED, 32'h0000_0041, 1'b1);

    // Back to long key with a fresh KEY2 and a zero nonce
    wait_for_results();
    write_cfg(salsa_pkg::CFG_MODE, 64'd1);
    write_cfg(salsa_pkg::CFG_KEY2, rand64());
    write_cfg(salsa_pkg::CFG_NONCE, '0);
    push_byte(8'h00, 32'h0000_0080, 1'b0);
    push_byte(8'hFF, 32'h0000_00BF, 1'b0);
    push_byte(8'h69, 32'h0000_0040, 1'b1);
    push_byte(8'h96, 32'h7FFF_FFFF, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      wait_for_results();
      flow = flow_mode_t'(ph);
      case (flow)
        FLOW_FREE: begin
          write_cfg(salsa_pkg::CFG_KEY0, rand64());
          write_cfg(salsa_pkg::CFG_KEY1, rand64());
          write_cfg(salsa_pkg::CFG_KEY2, rand64());
          write_cfg(salsa_pkg::CFG_KEY3, rand64());
          write_cfg(salsa_pkg::CFG_NONCE, rand64());
          write_cfg(salsa_pkg::CFG_MODE, '0);
        end
        FLOW_SRC_GAPS: begin
          write_cfg(salsa_pkg::CFG_KEY0, '1);
          write_cfg(salsa_pkg::CFG_KEY1, rand64());
          write_cfg(salsa_pkg::CFG_KEY2, '0);
          write_cfg(salsa_pkg::CFG_KEY3, rand64());
          write_cfg(salsa_pkg::CFG_NONCE, rand64());
          write_cfg(salsa_pkg::CFG_MODE, rand64() | 64'd1);
        end
        FLOW_SINK_STALLS: begin
          write_cfg(salsa_pkg::CFG_KEY0, '0);
          write_cfg(salsa_pkg::CFG_KEY1, '0);
          write_cfg(salsa_pkg::CFG_KEY2, rand64());
          write_cfg(salsa_pkg::CFG_KEY3, '1);
          write_cfg(salsa_pkg::CFG_NONCE, rand64());
          write_cfg(salsa_pkg::CFG_MODE, rand64() & ~64'd1);
        end
        default: begin
          write_cfg(salsa_pkg::CFG_KEY0, rand64());
          write_cfg(salsa_pkg::CFG_KEY1, rand64());
          write_cfg(salsa_pkg::CFG_KEY2, rand64());
          write_cfg(salsa_pkg::CFG_KEY3, rand64());
          write_cfg(salsa_pkg::CFG_NONCE, '1);
          write_cfg(salsa_pkg::CFG_MODE, 64'd1);
        end
      endcase
      write_cfg(CFG_SPARE_LO + 3'($urandom_range(1)), rand64());

      sent   = 0;
      paused = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // Halfway: let the pipe run dry, then change the nonce
        if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
          wait_for_results();
          write_cfg(salsa_pkg::CFG_NONCE, rand64());
          paused = 1;
        end
        src_steady = ($urandom_range(4) == 0);
        pick = $urandom_range(99);
        if (pick < 80) begin
          // Message: consecutive positions from a mostly low start
          len = $urandom_range(96, 1);
          if (len > ITEMS_PER_PHASE - sent)
            len = ITEMS_PER_PHASE - sent;
          pick = $urandom_range(9);
          if (pick < 7)
            start = $urandom_range(4095);
          else if (pick < 9)
            start = $urandom;
          else
            start = 32'hFFFF_FFFF - $urandom_range(200);
          for (int i = 0; i < len; i++)
            push_byte(8'($urandom), start + i, i == len - 1);
          sent += len;
        end else begin
          push_byte(8'($urandom), $urandom, 1'($urandom_range(1)));
          sent++;
        end
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t ERROR %0d expected bytes never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("Checked %0d bytes over %0d keystream blocks and %0d register writes,",
             sb.checked, sb.rebuilds, cfg_writes);
    $display("with short and long keys, wrapping positions and four flow-control mixes.");
    if (sb.errors == 0)
      $display("salsa20_stream_cipher_top_tb: clean");
    else
      $display("salsa20_stream_cipher_top_tb: errors");
    $finish;
  end

endmodule

>>> salsa20_stream_cipher_top.f
hdl/salsa_pkg.sv
hdl/salsa_ctrl.sv
hdl/salsa_datapath.sv
hdl/salsa20_stream_cipher_top.sv
dv/salsa20_stream_cipher_top_tb.sv
